// ===== rtl/mmrs_pkg.sv =====
// Shared types and constants for the row-slice matrix multiply-accumulate block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mmrs_pkg;

  localparam int DEF_MAX_ORDER = 16;
  localparam int CFG_W = 5;     // width of every configuration register
  localparam int CELL_AW = 12;  // address width for the largest supported order

  localparam logic [CFG_W-1:0] ORDER_RST = 5'd16;
  localparam logic [CFG_W-1:0] LANES_RST = 5'd1;
  localparam logic [CFG_W-1:0] LANE_RST  = 5'd1;

  // configuration register indexes
  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_LANES = 2'd1;
  localparam logic [1:0] REG_LANE  = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_COMPUTE = 2'd1,
    FN_READ    = 2'd2,
    FN_CLEAR   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_DIV,
    ST_SLICE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic               ab_we;
    logic [CELL_AW-1:0] ab_waddr;
    logic [CELL_AW-1:0] a_raddr;
    logic [CELL_AW-1:0] b_raddr;
    logic [CELL_AW-1:0] c_raddr;
    logic               c_clr;
    logic [CELL_AW-1:0] c_clr_addr;
    logic               mac_vld;
    logic               mac_first;
    logic               mac_last;
    logic               out_load_rd;
    logic               rd_zero;
    logic               out_load_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic pipe_busy;
  } sts_t;

endpackage

// ===== rtl/mmrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module mmrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mmrs_ctrl.sv =====
// Controller: configuration registers, state machine, slice setup and loop counters.
// Depends on mmrs_pkg; drives the datapath through cmd_t, watches sts_t.
module mmrs_ctrl #(
  parameter int MAX_ORDER = mmrs_pkg::DEF_MAX_ORDER
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [mmrs_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [1:0]                  in_func,
  input  logic [3:0]                  in_row,
  input  logic [3:0]                  in_col,
  input  mmrs_pkg::sts_t              sts,
  output mmrs_pkg::cmd_t              cmd
);
  import mmrs_pkg::*;

  localparam int CELLS = MAX_ORDER * MAX_ORDER;
  localparam int AW = $clog2(CELLS);

  state_t state_r, state_nxt;
  logic [CFG_W-1:0] order_r, lanes_r, lane_r;
  logic [CFG_W-1:0] m_eff, lc_eff;
  logic [CFG_W-1:0] rem_r, rem_nxt, per_r, per_nxt;
  logic [CFG_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, end_r, end_nxt;
  logic [AW-1:0]    clr_r, clr_nxt, rd_addr_r, rd_addr_nxt;
  logic             rd_in_r, rd_in_nxt;
  logic             accept, in_range, empty, k_last, j_last, i_last;
  logic [9:0]       start10, end10;
  func_t            func;

  function automatic logic [AW-1:0] cell_idx(input logic [CFG_W-1:0] r,
                                             input logic [CFG_W-1:0] c);
    cell_idx = AW'(r) * AW'(MAX_ORDER) + AW'(c);
  endfunction

  // effective order and lane count
  assign m_eff  = (32'(order_r) > MAX_ORDER) ? CFG_W'(MAX_ORDER) : order_r;
  assign lc_eff = (lanes_r == '0) ? CFG_W'(1) : lanes_r;
  assign empty  = (m_eff == '0) || (lane_r == '0) || (lane_r > lc_eff);

  assign func     = func_t'(in_func);
  assign accept   = in_tvalid && in_tready;
  assign in_range = ({1'b0, in_row} < m_eff) && ({1'b0, in_col} < m_eff);

  // slice bounds from quotient and remainder
  always_comb begin
    start10 = 10'(lane_r - CFG_W'(1)) * 10'(per_r);
    end10   = start10 + 10'(per_r) + ((lane_r == lc_eff) ? 10'(rem_r) : 10'd0);
    if (end10 > 10'(m_eff)) begin
      end10 = 10'(m_eff);
    end
  end

  assign k_last = (k_r == m_eff - CFG_W'(1));
  assign j_last = (j_r == m_eff - CFG_W'(1));
  assign i_last = (i_r == end_r - CFG_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (clr_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FN_COMPUTE: state_nxt = ST_DIV;
            FN_READ:    state_nxt = ST_RD;
            FN_CLEAR:   state_nxt = ST_CLR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:    if (sts.out_free) state_nxt = ST_IDLE;
      ST_DIV: begin
        if (empty) begin
          state_nxt = ST_DRAIN;
        end else if (rem_r < lc_eff) begin
          state_nxt = ST_SLICE;
        end
      end
      ST_SLICE: state_nxt = (start10 >= end10) ? ST_DRAIN : ST_MAC;
      ST_MAC:   if (k_last && j_last && i_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!sts.pipe_busy) state_nxt = ST_DONE;
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // counters and captured request fields
  always_comb begin
    rem_nxt     = rem_r;
    per_nxt     = per_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    end_nxt     = end_r;
    clr_nxt     = clr_r;
    rd_addr_nxt = rd_addr_r;
    rd_in_nxt   = rd_in_r;
    case (state_r)
      ST_CLR: clr_nxt = clr_r + AW'(1);
      ST_IDLE: begin
        clr_nxt     = '0;
        rem_nxt     = m_eff;
        per_nxt     = '0;
        rd_addr_nxt = cell_idx({1'b0, in_row}, {1'b0, in_col});
        rd_in_nxt   = in_range;
      end
      ST_DIV: begin
        if (rem_r >= lc_eff) begin
          rem_nxt = rem_r - lc_eff;
          per_nxt = per_r + CFG_W'(1);
        end
      end
      ST_SLICE: begin
        i_nxt   = start10[CFG_W-1:0];
        end_nxt = end10[CFG_W-1:0];
        j_nxt   = '0;
        k_nxt   = '0;
      end
      ST_MAC: begin
        k_nxt = k_last ? '0 : k_r + CFG_W'(1);
        if (k_last) begin
          j_nxt = j_last ? '0 : j_r + CFG_W'(1);
          if (j_last) begin
            i_nxt = i_r + CFG_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_tready         = (state_r == ST_IDLE);
    cmd               = '0;
    cmd.ab_we         = (state_r == ST_IDLE) && accept && (func == FN_LOAD) && in_range;
    cmd.ab_waddr      = CELL_AW'(cell_idx({1'b0, in_row}, {1'b0, in_col}));
    cmd.a_raddr       = CELL_AW'(cell_idx(i_r, k_r));
    cmd.b_raddr       = CELL_AW'(cell_idx(k_r, j_r));
    cmd.c_raddr       = CELL_AW'(rd_addr_r);
    cmd.c_clr_addr    = CELL_AW'(clr_r);
    cmd.rd_zero       = !rd_in_r;
    case (state_r)
      ST_CLR:  cmd.c_clr = 1'b1;
      ST_IDLE: cmd.c_raddr = CELL_AW'(cell_idx({1'b0, in_row}, {1'b0, in_col}));
      ST_RD:   cmd.out_load_rd = sts.out_free;
      ST_MAC: begin
        cmd.c_raddr   = CELL_AW'(cell_idx(i_r, j_r));
        cmd.mac_vld   = 1'b1;
        cmd.mac_first = (k_r == '0);
        cmd.mac_last  = k_last;
      end
      ST_DONE: cmd.out_load_done = sts.out_free;
      default: ;
    endcase
  end

  // state, configuration and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      order_r <= ORDER_RST;
      lanes_r <= LANES_RST;
      lane_r  <= LANE_RST;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_ORDER: order_r <= cfg_wdata;
          REG_LANES: lanes_r <= cfg_wdata;
          REG_LANE:  lane_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    per_r     <= per_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    end_r     <= end_nxt;
    rd_addr_r <= rd_addr_nxt;
    rd_in_r   <= rd_in_nxt;
  end

endmodule

// ===== rtl/mmrs_dp.sv =====
// Datapath: A, B and C stores, multiply pipeline, saturating accumulator, result register.
// Depends on mmrs_pkg and mmrs_ram; steered by cmd_t from mmrs_ctrl.
module mmrs_dp #(
  parameter int MAX_ORDER = mmrs_pkg::DEF_MAX_ORDER
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mmrs_pkg::cmd_t cmd,
  output mmrs_pkg::sts_t sts,
  input  logic [31:0]    a_value,
  input  logic [31:0]    b_value,
  output logic           out_vld,
  input  logic           out_rdy,
  output logic           out_kind,
  output logic [63:0]    out_c_value,
  output logic           out_overflow
);
  import mmrs_pkg::*;

  localparam int CELLS = MAX_ORDER * MAX_ORDER;
  localparam int AW = $clog2(CELLS);

  logic [31:0]        a_q, b_q;
  logic [63:0]        c_q;
  logic               p1_vld_r, p1_first_r, p1_last_r;
  logic               p2_vld_r, p2_first_r, p2_last_r;
  logic               p3_vld_r, p3_last_r;
  logic [AW-1:0]      p1_addr_r, p2_addr_r, p3_addr_r;
  logic signed [63:0] prod_r, base_r, acc_r, acc_in, sum;
  logic               ovf_r, sat;
  logic               c_we;
  logic [AW-1:0]      c_waddr;
  logic [63:0]        c_wdata;
  logic               out_vld_r, kind_r, oflag_r;
  logic [63:0]        cval_r;

  mmrs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_a_ram (
    .clk(clk), .we(cmd.ab_we), .waddr(cmd.ab_waddr[AW-1:0]), .wdata(a_value),
    .raddr(cmd.a_raddr[AW-1:0]), .rdata(a_q)
  );

  mmrs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_b_ram (
    .clk(clk), .we(cmd.ab_we), .waddr(cmd.ab_waddr[AW-1:0]), .wdata(b_value),
    .raddr(cmd.b_raddr[AW-1:0]), .rdata(b_q)
  );

  // clear sweep and accumulator writeback share the C write port
  assign c_we    = cmd.c_clr || (p3_vld_r && p3_last_r);
  assign c_waddr = cmd.c_clr ? cmd.c_clr_addr[AW-1:0] : p3_addr_r;
  assign c_wdata = cmd.c_clr ? 64'd0 : acc_r;

  mmrs_ram #(.WIDTH(64), .DEPTH(CELLS)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(cmd.c_raddr[AW-1:0]), .rdata(c_q)
  );

  // saturating add of product into running sum
  always_comb begin
    acc_in = p2_first_r ? base_r : acc_r;
    sum    = acc_in + prod_r;
    sat    = (acc_in[63] == prod_r[63]) && (sum[63] != acc_in[63]);
  end

  // pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      p1_vld_r <= cmd.mac_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      if (p2_vld_r && sat) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // multiply, hold base and accumulate
  always_ff @(posedge clk) begin
    p1_first_r <= cmd.mac_first;
    p1_last_r  <= cmd.mac_last;
    p1_addr_r  <= cmd.c_raddr[AW-1:0];
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    p2_addr_r  <= p1_addr_r;
    p3_last_r  <= p2_last_r;
    p3_addr_r  <= p2_addr_r;
    prod_r     <= signed'(a_q) * signed'(b_q);
    base_r     <= signed'(c_q);
    if (p2_vld_r) begin
      acc_r <= sat ? (acc_in[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load_rd || cmd.out_load_done) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_rd || cmd.out_load_done) begin
      kind_r  <= cmd.out_load_done ? KIND_DONE : KIND_READ;
      cval_r  <= (cmd.out_load_done || cmd.rd_zero) ? 64'd0 : c_q;
      oflag_r <= ovf_r;
    end
  end

  assign sts.out_free  = !out_vld_r || out_rdy;
  assign sts.pipe_busy = p1_vld_r || p2_vld_r || p3_vld_r;
  assign out_vld       = out_vld_r;
  assign out_kind      = kind_r;
  assign out_c_value   = cval_r;
  assign out_overflow  = oflag_r;

endmodule

// ===== rtl/matrix_multiply_row_slice.sv =====
// Top level of the row-slice matrix multiply-accumulate lane.
// Depends on mmrs_pkg, mmrs_ctrl, mmrs_dp (and mmrs_ram through it).
//
//  port group | dir | fields (low bit first)
//  in_        | in  | tdata: row[3:0] col[7:4] a_value[39:8] b_value[71:40]; tuser: func
//  out_       | out | tdata: c_value[63:0] overflow[64] zero[71:65]; tuser: kind
//  cfg_       | in  | addr 0 matrix_order, 1 lane_count, 2 lane_index; wdata 5 bits
//
// A load writes A and B when it is accepted. Clear writes one C entry a cycle.
// Compute accepts, divides, sets up the slice, runs one multiply-accumulate a cycle, drains
// and gives a done beat; an empty lane skips the multiply-accumulate loop.
// After reset the same C sweep runs with in_tready low.
// A waiting result does not block loads and clears; reads and computes wait for it.
module matrix_multiply_row_slice #(
  parameter int MAX_ORDER = mmrs_pkg::DEF_MAX_ORDER
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [mmrs_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [71:0]                in_tdata,   // row, col, a_value, b_value
  input  logic [1:0]                 in_tuser,   // func
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [71:0]                out_tdata,  // c_value, overflow, zero pad
  output logic [0:0]                 out_tuser   // kind
);
  import mmrs_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        kind, ovf;
  logic [63:0] cval;

  mmrs_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_func(in_tuser), .in_row(in_tdata[3:0]), .in_col(in_tdata[7:4]),
    .sts(sts), .cmd(cmd)
  );

  mmrs_dp #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .a_value(in_tdata[39:8]), .b_value(in_tdata[71:40]),
    .out_vld(out_tvalid), .out_rdy(out_tready),
    .out_kind(kind), .out_c_value(cval), .out_overflow(ovf)
  );

  assign out_tdata = {7'd0, ovf, cval};
  assign out_tuser = kind;

endmodule

// ===== rtl/mmrs_checker.sv =====
// Port-level checker for matrix_multiply_row_slice, attached by bind.
// Depends on mmrs_pkg for the result kind codes.
module mmrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import mmrs_pkg::*;

  logic seen_r;

  // remember an overflow shown on any beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tdata[64]) begin
      seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_r |-> out_tdata[64])
    else $error("overflow flag fell after being reported");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_DONE) |-> (out_tdata[63:0] == 64'd0))
    else $error("done beat carries nonzero data");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during clear sweep");

endmodule

bind matrix_multiply_row_slice mmrs_checker u_mmrs_checker (.*);
